@@ hw/rtl/double_clap_detector_macros.svh @@
// Assertion macros for the double clap detector.
// Included by double_clap_detector, which carries the concurrent checks; needs aclk and aresetn in scope.
`ifndef DOUBLE_CLAP_DETECTOR_MACROS_SVH
`define DOUBLE_CLAP_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that is held off while reset is asserted.
`define DCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("double_clap_detector check failed");

// Check that also holds during reset.
`define DCD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("double_clap_detector check failed");

`else

`define DCD_ASSERT(lbl, prop)
`define DCD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ hw/rtl/dcd_pkg.sv @@
// Shared types and constants for the double clap detector.
// No dependencies; used by dcd_engine and double_clap_detector.
package dcd_pkg;

    localparam int CFG_W = 10;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_END      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_ONE_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CLAP_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TWO_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_END     = 3'd4;

    localparam logic [CFG_W-1:0] RST_IGNORE_END      = 10'd35;
    localparam logic [CFG_W-1:0] RST_QUIET_ONE_END   = 10'd125;
    localparam logic [CFG_W-1:0] RST_SECOND_CLAP_END = 10'd250;
    localparam logic [CFG_W-1:0] RST_QUIET_TWO_END   = 10'd300;
    localparam logic [CFG_W-1:0] RST_LOCKOUT_END     = 10'd800;

    // event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;

    typedef struct packed {
        logic mic_level;
        logic tick;
    } dcd_in_t;

    typedef struct packed {
        logic       output_on;
        logic       busy_res;
        logic [1:0] event_res;
    } dcd_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] ignore_end;
        logic [CFG_W-1:0] quiet_one_end;
        logic [CFG_W-1:0] second_clap_end;
        logic [CFG_W-1:0] quiet_two_end;
        logic [CFG_W-1:0] lockout_end;
    } dcd_cfg_t;

endpackage

@@ hw/rtl/double_clap_detector.sv @@
// Top level of the double clap detector: handshakes, configuration registers, result register.
// Depends on dcd_pkg, dcd_engine and double_clap_detector_macros.svh.
//
// Usage:
//   s_ channel: one transfer per microphone sample, carrying the comparator level and a
//   flag for a timer tick that elapsed after the sample.
//   m_ channel: exactly one result per input transfer, in order: the output state, a busy
//   flag for a check in progress and an event code (none, accepted and toggled, rejected).
//   cfg_ channel: writes the five window bounds (tick counts, 10 bits); always ready.
//   Writes to indexes beyond the list are dropped. Write only while no result is pending.
// Timing:
//   A sample taken in one cycle has its result on m_ in the cycle after.
//   Throughput is one item per cycle unless m_ready stalls; the window decisions are a short
//   compare chain between the engine state registers and the result register.
// Reset: window bounds return to 35/125/250/300/800 ticks, the check goes idle,
//   the output is off and no result is pending.
// Stall: while a result waits and m_ready is low, s_ready is low; nothing is dropped.
`include "double_clap_detector_macros.svh"

module double_clap_detector #(
    parameter int COUNT_BITS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dcd_pkg::dcd_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dcd_pkg::dcd_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcd_pkg::CFG_W-1:0]        cfg_data
);

    dcd_pkg::dcd_cfg_t cfg_reg;
    dcd_pkg::dcd_out_t result_next;
    dcd_pkg::dcd_out_t m_data_reg;
    logic              m_valid_reg;
    logic              s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ignore_end      <= dcd_pkg::RST_IGNORE_END;
            cfg_reg.quiet_one_end   <= dcd_pkg::RST_QUIET_ONE_END;
            cfg_reg.second_clap_end <= dcd_pkg::RST_SECOND_CLAP_END;
            cfg_reg.quiet_two_end   <= dcd_pkg::RST_QUIET_TWO_END;
            cfg_reg.lockout_end     <= dcd_pkg::RST_LOCKOUT_END;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dcd_pkg::CFG_IGNORE_END:      cfg_reg.ignore_end      <= cfg_data;
                dcd_pkg::CFG_QUIET_ONE_END:   cfg_reg.quiet_one_end   <= cfg_data;
                dcd_pkg::CFG_SECOND_CLAP_END: cfg_reg.second_clap_end <= cfg_data;
                dcd_pkg::CFG_QUIET_TWO_END:   cfg_reg.quiet_two_end   <= cfg_data;
                dcd_pkg::CFG_LOCKOUT_END:     cfg_reg.lockout_end     <= cfg_data;
                default: ;
            endcase
        end
    end

    dcd_engine #(
        .COUNT_BITS(COUNT_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_fire),
        .in_data (s_data),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= result_next;
        end
    end

    // every input transfer leaves a result behind
    `DCD_ASSERT(a_fire_gives_result, s_fire |=> m_valid)
    // a pending result that is not taken blocks the input
    `DCD_ASSERT_ALWAYS(a_no_overwrite, (m_valid_reg && !m_ready) |-> !s_ready)
    // an accept or reject always ends the check
    `DCD_ASSERT(a_event_ends_check,
        (s_fire && result_next.event_res != dcd_pkg::EV_NONE) |=> !m_data.busy_res)
    // output state moves only with an accept event
    `DCD_ASSERT(a_toggle_only_on_accept,
        (s_fire && m_valid && result_next.event_res != dcd_pkg::EV_ACCEPT)
            |-> (result_next.output_on == m_data.output_on))

endmodule

@@ hw/rtl/dcd_engine.sv @@
// Detection state machine: holds the check phase, tick count and output state.
// Depends on dcd_pkg; produces the result of each transfer combinationally.
module dcd_engine #(
    parameter int COUNT_BITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  dcd_pkg::dcd_in_t  in_data,
    input  dcd_pkg::dcd_cfg_t cfg,
    output dcd_pkg::dcd_out_t result
);

    localparam int CMP_W = (COUNT_BITS > dcd_pkg::CFG_W) ? COUNT_BITS : dcd_pkg::CFG_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IGNORE,
        PH_QUIET1,
        PH_SECOND,
        PH_QUIET2,
        PH_LOCKOUT
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  pass_reg, pass_next;
    logic                  out_reg, out_next;
    logic                  last_mic_reg;
    logic [1:0]            event_code;
    logic [4:0]            reached;

    function automatic logic hit(input logic [COUNT_BITS-1:0] cnt,
                                 input logic [dcd_pkg::CFG_W-1:0] bound);
        return (CMP_W'(cnt) >= CMP_W'(bound)) || (cnt == COUNT_MAX);
    endfunction

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        out_next   = out_reg;
        event_code = dcd_pkg::EV_NONE;

        unique case (phase_reg) inside
            PH_IDLE: begin
                if (in_data.mic_level != last_mic_reg) begin
                    count_next = '0;
                    pass_next  = 1'b1;
                    phase_next = PH_IGNORE;
                end
            end
            PH_IGNORE, PH_LOCKOUT: ;
            PH_QUIET1, PH_QUIET2: begin
                if (in_data.mic_level) pass_next = 1'b0;
            end
            PH_SECOND: begin
                if (in_data.mic_level) pass_next = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase

        if (phase_reg != PH_IDLE && in_data.tick && count_reg != COUNT_MAX)
            count_next = count_reg + COUNT_BITS'(1);

        reached[0] = hit(count_next, cfg.ignore_end);
        reached[1] = hit(count_next, cfg.quiet_one_end);
        reached[2] = hit(count_next, cfg.second_clap_end);
        reached[3] = hit(count_next, cfg.quiet_two_end);
        reached[4] = hit(count_next, cfg.lockout_end);

        // leave every window whose end is reached, in order
        if (phase_next == PH_IGNORE && reached[0])
            phase_next = PH_QUIET1;
        if (phase_next == PH_QUIET1 && reached[1]) begin
            if (!pass_next) begin
                phase_next = PH_IDLE;
                event_code = dcd_pkg::EV_REJECT;
            end else begin
                pass_next  = 1'b0;
                phase_next = PH_SECOND;
            end
        end
        if (phase_next == PH_SECOND && reached[2]) begin
            if (!pass_next) begin
                phase_next = PH_IDLE;
                event_code = dcd_pkg::EV_REJECT;
            end else begin
                phase_next = PH_QUIET2;
            end
        end
        if (phase_next == PH_QUIET2 && reached[3]) begin
            if (!pass_next) begin
                phase_next = PH_IDLE;
                event_code = dcd_pkg::EV_REJECT;
            end else begin
                phase_next = PH_LOCKOUT;
            end
        end
        if (phase_next == PH_LOCKOUT && reached[4]) begin
            out_next   = ~out_reg;
            phase_next = PH_IDLE;
            event_code = dcd_pkg::EV_ACCEPT;
        end

        result.output_on = out_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.event_res = event_code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            pass_reg     <= 1'b0;
            out_reg      <= 1'b0;
            last_mic_reg <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            pass_reg     <= pass_next;
            out_reg      <= out_next;
            last_mic_reg <= in_data.mic_level;
        end
    end

endmodule

@@ verif/double_clap_detector_test.sv @@
// Self-checking testbench for double_clap_detector: directed plan, then random clap sequences.
// A local predictor of the clap windows checks every result; depends only on dcd_pkg and the RTL.
module double_clap_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLES_PER_PHASE = 25;
    localparam int RAND_PHASES       = 8;
    localparam int HOLD_CYCLES       = 80;
    localparam int MAX_REPORTS       = 10;

    localparam logic [dcd_pkg::CFG_W-1:0]     BOUND_MAX       = '1;
    localparam logic [dcd_pkg::CFG_IDX_W-1:0] IDX_SPARE_FIRST =
        dcd_pkg::CFG_LOCKOUT_END + 1'b1;
    localparam logic [dcd_pkg::CFG_IDX_W-1:0] IDX_SPARE_LAST  = '1;

    typedef enum logic [2:0] {
        CHK_IDLE, CHK_IGNORE, CHK_QUIET1, CHK_SECOND, CHK_QUIET2, CHK_LOCKOUT
    } chk_phase_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_RUN_OUT} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic [dcd_pkg::CFG_IDX_W-1:0] idx;
        logic [dcd_pkg::CFG_W-1:0]     val;
        dcd_pkg::dcd_in_t              sample;
        bit                            known;
        dcd_pkg::dcd_out_t             want;
    } plan_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    dcd_pkg::dcd_in_t  s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    dcd_pkg::dcd_out_t m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dcd_pkg::CFG_W-1:0]     cfg_data  = '0;

    // clap check state as the block should hold it
    chk_phase_t                chk_phase = CHK_IDLE;
    logic [dcd_pkg::CFG_W-1:0] ticks     = '0;
    logic                      armed     = 1'b0;
    logic                      out_state = 1'b0;
    logic                      prev_mic  = 1'b0;
    logic [dcd_pkg::CFG_W-1:0] bnd_ignore  = dcd_pkg::RST_IGNORE_END;
    logic [dcd_pkg::CFG_W-1:0] bnd_quiet1  = dcd_pkg::RST_QUIET_ONE_END;
    logic [dcd_pkg::CFG_W-1:0] bnd_second  = dcd_pkg::RST_SECOND_CLAP_END;
    logic [dcd_pkg::CFG_W-1:0] bnd_quiet2  = dcd_pkg::RST_QUIET_TWO_END;
    logic [dcd_pkg::CFG_W-1:0] bnd_lockout = dcd_pkg::RST_LOCKOUT_END;

    dcd_pkg::dcd_out_t expected_q[$];
    plan_row_t         plan[$];

    int                mismatches    = 0;
    int                results_seen  = 0;
    int                samples_sent  = 0;
    int                random_sent   = 0;
    int                bound_sets    = 0;
    int                claps_taken   = 0;
    int                checks_killed = 0;

    double_clap_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit bound_hit(logic [dcd_pkg::CFG_W-1:0] bound);
        return ticks >= bound || ticks == BOUND_MAX;
    endfunction

    // Leave every window whose end the count has reached; returns the event code.
    function automatic logic [1:0] close_windows();
        logic [1:0] ev;
        bit         open;
        ev = dcd_pkg::EV_NONE;
        open = 1'b1;
        while (open) begin
            case (chk_phase)
                CHK_IGNORE: begin
                    if (bound_hit(bnd_ignore)) chk_phase = CHK_QUIET1;
                    else open = 1'b0;
                end
                CHK_QUIET1: begin
                    if (!bound_hit(bnd_quiet1)) begin
                        open = 1'b0;
                    end else if (!armed) begin
                        chk_phase = CHK_IDLE;
                        ev = dcd_pkg::EV_REJECT;
                        open = 1'b0;
                    end else begin
                        armed = 1'b0;
                        chk_phase = CHK_SECOND;
                    end
                end
                CHK_SECOND: begin
                    if (!bound_hit(bnd_second)) begin
                        open = 1'b0;
                    end else if (!armed) begin
                        chk_phase = CHK_IDLE;
                        ev = dcd_pkg::EV_REJECT;
                        open = 1'b0;
                    end else begin
                        chk_phase = CHK_QUIET2;
                    end
                end
                CHK_QUIET2: begin
                    if (!bound_hit(bnd_quiet2)) begin
                        open = 1'b0;
                    end else if (!armed) begin
                        chk_phase = CHK_IDLE;
                        ev = dcd_pkg::EV_REJECT;
                        open = 1'b0;
                    end else begin
                        chk_phase = CHK_LOCKOUT;
                    end
                end
                CHK_LOCKOUT: begin
                    if (bound_hit(bnd_lockout)) begin
                        out_state = ~out_state;
                        chk_phase = CHK_IDLE;
                        ev = dcd_pkg::EV_ACCEPT;
                    end
                    open = 1'b0;
                end
                default: begin
                    chk_phase = CHK_IDLE;
                    open = 1'b0;
                end
            endcase
        end
        return ev;
    endfunction

    function automatic dcd_pkg::dcd_out_t predict_clap(dcd_pkg::dcd_in_t smp);
        dcd_pkg::dcd_out_t r;
        logic [1:0]        ev;
        ev = dcd_pkg::EV_NONE;
        if (chk_phase == CHK_IDLE) begin
            if (smp.mic_level != prev_mic) begin
                ticks = '0;
                armed = 1'b1;
                chk_phase = CHK_IGNORE;
                ev = close_windows();
            end
        end else begin
            // sample first, then count the tick, then close windows
            if (smp.mic_level) begin
                if (chk_phase == CHK_QUIET1 || chk_phase == CHK_QUIET2) armed = 1'b0;
                else if (chk_phase == CHK_SECOND) armed = 1'b1;
            end
            if (smp.tick && ticks != BOUND_MAX) ticks = ticks + 1'b1;
            ev = close_windows();
        end
        prev_mic = smp.mic_level;
        r.output_on = out_state;
        r.busy_res  = (chk_phase != CHK_IDLE);
        r.event_res = ev;
        return r;
    endfunction

    // Biased toward well-formed clap pairs, with some noise on top.
    function automatic dcd_pkg::dcd_in_t next_sample();
        dcd_pkg::dcd_in_t smp;
        int unsigned      roll;
        roll = $urandom_range(0, 99);
        smp.tick = ($urandom_range(0, 99) < 75);
        case (chk_phase) inside
            CHK_IDLE:               smp.mic_level = (roll < 40) ? ~prev_mic : prev_mic;
            CHK_QUIET1, CHK_QUIET2: smp.mic_level = (roll < 6);
            CHK_SECOND:             smp.mic_level = (roll < 35);
            default:                smp.mic_level = roll[0];
        endcase
        if ($urandom_range(0, 9) == 0) smp = dcd_pkg::dcd_in_t'(2'($urandom_range(0, 3)));
        return smp;
    endfunction

    function automatic void put_sample(logic mic, logic tck);
        plan.push_back('{ROW_SAMPLE, '0, '0, '{mic_level: mic, tick: tck}, 1'b0, '0});
    endfunction

    function automatic void put_known(logic mic, logic tck, logic on, logic busy,
                                      logic [1:0] ev);
        plan.push_back('{ROW_SAMPLE, '0, '0, '{mic_level: mic, tick: tck}, 1'b1,
                         '{output_on: on, busy_res: busy, event_res: ev}});
    endfunction

    function automatic void put_write(logic [dcd_pkg::CFG_IDX_W-1:0] idx,
                                      logic [dcd_pkg::CFG_W-1:0] val);
        plan.push_back('{ROW_WRITE, idx, val, '0, 1'b0, '0});
    endfunction

    function automatic void put_run_out();
        plan.push_back('{ROW_RUN_OUT, '0, '0, '0, 1'b0, '0});
    endfunction

    task automatic send_sample(dcd_pkg::dcd_in_t smp, bit known, dcd_pkg::dcd_out_t want);
        dcd_pkg::dcd_out_t r;
        if (cfg_valid) cfg_valid <= 1'b0;
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = predict_clap(smp);
        expected_q.push_back(known ? want : r);
        samples_sent++;
    endtask

    // Quiet ticking samples until the open check has ended.
    task automatic run_out_check();
        while (chk_phase != CHK_IDLE)
            send_sample('{mic_level: 1'b0, tick: 1'b1}, 1'b0, '0);
    endtask

    task automatic quiesce();
        if (s_valid) s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [dcd_pkg::CFG_IDX_W-1:0] idx,
                             logic [dcd_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            dcd_pkg::CFG_IGNORE_END:      bnd_ignore  = val;
            dcd_pkg::CFG_QUIET_ONE_END:   bnd_quiet1  = val;
            dcd_pkg::CFG_SECOND_CLAP_END: bnd_second  = val;
            dcd_pkg::CFG_QUIET_TWO_END:   bnd_quiet2  = val;
            dcd_pkg::CFG_LOCKOUT_END:     bnd_lockout = val;
            default: ;
        endcase
    endtask

    function automatic void flag_mismatch(string what, logic [1:0] want, logic [1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s, result %0d: expected %0d, got %0d",
                     what, results_seen, want, got);
    endfunction

    always @(posedge aclk) begin
        dcd_pkg::dcd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, m_data.event_res);
            end else begin
                want = expected_q.pop_front();
                if (m_data.output_on !== want.output_on)
                    flag_mismatch("output_on", {1'b0, want.output_on},
                                  {1'b0, m_data.output_on});
                if (m_data.busy_res !== want.busy_res)
                    flag_mismatch("busy_res", {1'b0, want.busy_res},
                                  {1'b0, m_data.busy_res});
                if (m_data.event_res !== want.event_res)
                    flag_mismatch("event_res", want.event_res, m_data.event_res);
                if (want.event_res == dcd_pkg::EV_ACCEPT) claps_taken++;
                if (want.event_res == dcd_pkg::EV_REJECT) checks_killed++;
            end
            results_seen++;
        end
    end

    // Result side: rotating stall patterns, plus one long hold-off to back up the input.
    initial begin
        int unsigned cyc;
        bit          held;
        cyc = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held && random_sent >= 60) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                case ((cyc / 64) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ((cyc % 5) < 2);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // About six hundred samples under the slowest stalls; wide margin.
    initial begin
        #4_000_000;
        $display("timed out with %0d results pending", expected_q.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        int                        ph;
        int                        n;
        int                        burst;
        logic [dcd_pkg::CFG_W-1:0] b0, b1, b2, b3, b4;

        // reset bounds: idle samples, then a check with no second clap
        put_known(1'b0, 1'b0, 1'b0, 1'b0, dcd_pkg::EV_NONE);
        put_known(1'b0, 1'b1, 1'b0, 1'b0, dcd_pkg::EV_NONE);
        put_known(1'b1, 1'b1, 1'b0, 1'b1, dcd_pkg::EV_NONE);   // trigger, tick not counted
        put_sample(1'b0, 1'b1);
        put_sample(1'b1, 1'b0);                       // sound inside the ignore window
        put_run_out();
        // zero bounds: every window is already over at the trigger
        put_write(dcd_pkg::CFG_IGNORE_END,      '0);
        put_write(dcd_pkg::CFG_QUIET_ONE_END,   '0);
        put_write(dcd_pkg::CFG_SECOND_CLAP_END, '0);
        put_write(dcd_pkg::CFG_QUIET_TWO_END,   '0);
        put_write(dcd_pkg::CFG_LOCKOUT_END,     '0);
        put_known(1'b1, 1'b0, 1'b0, 1'b0, dcd_pkg::EV_REJECT);
        // spare indexes are dropped, so the zero bounds still hold
        put_write(IDX_SPARE_FIRST, BOUND_MAX);
        put_write(IDX_SPARE_FIRST + 1'b1, BOUND_MAX);
        put_write(IDX_SPARE_LAST, BOUND_MAX);
        put_known(1'b0, 1'b1, 1'b0, 1'b0, dcd_pkg::EV_REJECT);
        // short windows: a clean double clap toggles the output
        put_write(dcd_pkg::CFG_SECOND_CLAP_END, 10'd2);
        put_write(dcd_pkg::CFG_QUIET_TWO_END,   10'd2);
        put_write(dcd_pkg::CFG_LOCKOUT_END,     10'd3);
        put_sample(1'b1, 1'b0);
        put_sample(1'b1, 1'b1);
        put_sample(1'b0, 1'b1);
        put_known(1'b1, 1'b1, 1'b1, 1'b0, dcd_pkg::EV_ACCEPT);
        // sound in the second quiet window rejects and leaves the output alone
        put_write(dcd_pkg::CFG_QUIET_TWO_END, 10'd4);
        put_write(dcd_pkg::CFG_LOCKOUT_END,   10'd5);
        put_sample(1'b0, 1'b0);
        put_sample(1'b1, 1'b1);
        put_sample(1'b0, 1'b1);
        put_sample(1'b1, 1'b1);
        put_known(1'b0, 1'b1, 1'b1, 1'b0, dcd_pkg::EV_REJECT);
        // bounds out of order
        put_write(dcd_pkg::CFG_IGNORE_END,      10'd4);
        put_write(dcd_pkg::CFG_QUIET_ONE_END,   10'd1);
        put_write(dcd_pkg::CFG_SECOND_CLAP_END, 10'd6);
        put_write(dcd_pkg::CFG_QUIET_TWO_END,   10'd2);
        put_write(dcd_pkg::CFG_LOCKOUT_END,     10'd3);
        put_sample(1'b1, 1'b1);
        put_sample(1'b0, 1'b1);
        put_sample(1'b0, 1'b1);
        put_sample(1'b0, 1'b1);
        put_sample(1'b0, 1'b1);
        put_sample(1'b1, 1'b1);
        put_sample(1'b0, 1'b1);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE: begin
                    quiesce();
                    write_reg(plan[i].idx, plan[i].val);
                end
                ROW_SAMPLE:  send_sample(plan[i].sample, plan[i].known, plan[i].want);
                default:     run_out_check();
            endcase
        end
        bound_sets = 5;

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            quiesce();
            if (ph == 3 || ph == 6) begin
                b0 = dcd_pkg::CFG_W'($urandom_range(0, 12));
                b1 = dcd_pkg::CFG_W'($urandom_range(0, 12));
                b2 = dcd_pkg::CFG_W'($urandom_range(0, 12));
                b3 = dcd_pkg::CFG_W'($urandom_range(0, 12));
                b4 = dcd_pkg::CFG_W'($urandom_range(0, 12));
            end else begin
                b0 = dcd_pkg::CFG_W'($urandom_range(0, 4));
                b1 = b0 + dcd_pkg::CFG_W'($urandom_range(0, 8));
                b2 = b1 + dcd_pkg::CFG_W'($urandom_range(0, 8));
                b3 = b2 + dcd_pkg::CFG_W'($urandom_range(0, 6));
                b4 = b3 + dcd_pkg::CFG_W'($urandom_range(0, 10));
            end
            write_reg(dcd_pkg::CFG_IGNORE_END,      b0);
            write_reg(dcd_pkg::CFG_QUIET_ONE_END,   b1);
            write_reg(dcd_pkg::CFG_SECOND_CLAP_END, b2);
            write_reg(dcd_pkg::CFG_QUIET_TWO_END,   b3);
            write_reg(dcd_pkg::CFG_LOCKOUT_END,     b4);
            if (ph % 2 == 1)
                write_reg(dcd_pkg::CFG_IDX_W'($urandom_range(IDX_SPARE_FIRST, IDX_SPARE_LAST)),
                          dcd_pkg::CFG_W'($urandom_range(0, BOUND_MAX)));
            bound_sets++;
            burst = 0;
            for (n = 0; n < SAMPLES_PER_PHASE; n++) begin
                // odd phases send in bursts with gaps, even phases back to back
                if (ph % 2 == 1 && burst == 0) begin
                    s_valid <= 1'b0;
                    if (cfg_valid) cfg_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                    burst = $urandom_range(1, 12);
                end
                if (burst > 0) burst--;
                send_sample(next_sample(), 1'b0, '0);
                random_sent++;
            end
            run_out_check();
        end

        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d samples over %0d bound settings, %0d results checked",
                 samples_sent, bound_sets, results_seen);
        $display("%0d double claps accepted, %0d checks rejected, %0d mismatches",
                 claps_taken, checks_killed, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
